// ----- rtl/pal_pkg.sv -----
package pal_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int MOVES_W  = 6;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_LD
    } t_state;

    typedef struct packed {
        logic load;
        logic shift_init;
        logic shift_step;
        logic place;
        logic resp;
        logic dump_init;
        logic dump_ld;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              err;
        logic              moves_zero;
        logic              ptr_end;
        logic              dump_last;
        logic              out_free;
        logic              count_zero;
    } t_sts;

endpackage

// ----- rtl/pal_ram.sv -----
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pal_ctrl.sv -----
module pal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pal_pkg::t_sts  i_sts,
    output pal_pkg::t_cmd  o_cmd
);

    pal_pkg::t_state r_state;
    pal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            pal_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pal_pkg::S_CHECK;
                end
            end
            pal_pkg::S_CHECK: begin
                if (i_sts.err) begin
                    n_state = pal_pkg::S_RESP;
                end else begin
                    unique case (i_sts.func)
                        pal_pkg::FN_DUMP: begin
                            if (i_sts.count_zero) begin
                                n_state = pal_pkg::S_RESP;
                            end else begin
                                o_cmd.dump_init = 1'b1;
                                n_state         = pal_pkg::S_DUMP_RD;
                            end
                        end
                        default: begin
                            o_cmd.shift_init = 1'b1;
                            if (!i_sts.moves_zero) begin
                                n_state = pal_pkg::S_SHIFT;
                            end else if (i_sts.func == pal_pkg::FN_INSERT) begin
                                n_state = pal_pkg::S_PLACE;
                            end else begin
                                n_state = pal_pkg::S_RESP;
                            end
                        end
                    endcase
                end
            end
            pal_pkg::S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_sts.ptr_end) begin
                    n_state = pal_pkg::S_DRAIN;
                end
            end
            pal_pkg::S_DRAIN: begin
                if (i_sts.func == pal_pkg::FN_INSERT) begin
                    n_state = pal_pkg::S_PLACE;
                end else begin
                    n_state = pal_pkg::S_RESP;
                end
            end
            pal_pkg::S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = pal_pkg::S_RESP;
            end
            pal_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = pal_pkg::S_IDLE;
                end
            end
            pal_pkg::S_DUMP_RD: begin
                if (i_sts.out_free) begin
                    n_state = pal_pkg::S_DUMP_LD;
                end
            end
            pal_pkg::S_DUMP_LD: begin
                o_cmd.dump_ld = 1'b1;
                if (i_sts.dump_last) begin
                    n_state = pal_pkg::S_IDLE;
                end else begin
                    n_state = pal_pkg::S_DUMP_RD;
                end
            end
            default: begin
                n_state = pal_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/pal_dp.sv -----
module pal_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pal_pkg::t_cmd                       i_cmd,
    output pal_pkg::t_sts                       o_sts,
    input  logic [pal_pkg::FUNC_W-1:0]          i_func,
    input  logic [pal_pkg::POS_W-1:0]           i_position,
    input  logic signed [pal_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic                                o_status,
    output logic [pal_pkg::MOVES_W-1:0]         o_moves,
    output logic signed [pal_pkg::DATA_W-1:0]   o_item,
    output logic                                o_has_item,
    output logic                                o_last,
    output logic [pal_pkg::CNT_W-1:0]           o_count
);

    logic [pal_pkg::FUNC_W-1:0]  r_func;
    logic [pal_pkg::POS_W-1:0]   r_pos;
    logic [pal_pkg::DATA_W-1:0]  r_value;
    logic [pal_pkg::CNT_W-1:0]   r_count;
    logic [pal_pkg::CNT_W-1:0]   n_count;
    logic [pal_pkg::IDX_W-1:0]   r_ptr;
    logic [pal_pkg::IDX_W-1:0]   n_ptr;
    logic                        r_wr_pend;
    logic [pal_pkg::IDX_W-1:0]   r_wr_addr;

    logic                        r_o_valid;
    logic                        r_o_status;
    logic [pal_pkg::MOVES_W-1:0] r_o_moves;
    logic [pal_pkg::DATA_W-1:0]  r_o_item;
    logic                        r_o_has_item;
    logic                        r_o_last;
    logic [pal_pkg::CNT_W-1:0]   r_o_count;

    logic [pal_pkg::CNT_W-1:0]   diff;
    logic [pal_pkg::CNT_W-1:0]   moves_cur;
    logic [pal_pkg::IDX_W-1:0]   cnt_m1;
    logic [pal_pkg::IDX_W-1:0]   pos_idx;
    logic                        err;
    logic                        is_del;
    logic                        is_shift_op;
    logic                        mem_we;
    logic [pal_pkg::IDX_W-1:0]   mem_waddr;
    logic [pal_pkg::DATA_W-1:0]  mem_wdata;
    logic [pal_pkg::DATA_W-1:0]  mem_rdata;

    assign diff        = r_count - r_pos;
    assign is_del      = (r_func == pal_pkg::FN_DELETE);
    assign is_shift_op = (r_func == pal_pkg::FN_INSERT) || is_del;
    assign moves_cur   = is_del ? (diff - pal_pkg::CNT_W'(1)) : diff;
    assign cnt_m1      = pal_pkg::IDX_W'(r_count - pal_pkg::CNT_W'(1));
    assign pos_idx     = r_pos[pal_pkg::IDX_W-1:0];

    always_comb begin
        unique case (r_func)
            pal_pkg::FN_INSERT: err = (r_pos > r_count) ||
                                      (r_count >= pal_pkg::CNT_W'(pal_pkg::CAPACITY));
            pal_pkg::FN_DELETE: err = (r_pos >= r_count);
            pal_pkg::FN_DUMP:   err = 1'b0;
            default:            err = 1'b1;
        endcase
    end

    assign o_sts.func       = r_func;
    assign o_sts.err        = err;
    assign o_sts.moves_zero = (moves_cur == '0);
    assign o_sts.ptr_end    = is_del ? (r_ptr == cnt_m1) : (r_ptr == pos_idx);
    assign o_sts.dump_last  = (r_ptr == cnt_m1);
    assign o_sts.out_free   = !r_o_valid || i_ready;
    assign o_sts.count_zero = (r_count == '0);

    // Write port: a pending shift write wins; the placed value goes in after any drain.
    assign mem_we    = r_wr_pend || i_cmd.place;
    assign mem_waddr = r_wr_pend ? r_wr_addr : pos_idx;
    assign mem_wdata = r_wr_pend ? mem_rdata : r_value;

    pal_ram #(
        .WIDTH (pal_pkg::DATA_W),
        .DEPTH (pal_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.shift_init) begin
            n_ptr = is_del ? (pos_idx + pal_pkg::IDX_W'(1)) : cnt_m1;
        end else if (i_cmd.shift_step) begin
            n_ptr = is_del ? (r_ptr + pal_pkg::IDX_W'(1)) : (r_ptr - pal_pkg::IDX_W'(1));
        end else if (i_cmd.dump_init) begin
            n_ptr = '0;
        end else if (i_cmd.dump_ld) begin
            n_ptr = r_ptr + pal_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.resp && !err) begin
            if (r_func == pal_pkg::FN_INSERT) begin
                n_count = r_count + pal_pkg::CNT_W'(1);
            end else if (is_del) begin
                n_count = r_count - pal_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wr_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_wr_pend <= i_cmd.shift_step;
            if (i_cmd.resp || i_cmd.dump_ld) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        r_ptr <= n_ptr;
        if (i_cmd.shift_step) begin
            r_wr_addr <= is_del ? (r_ptr - pal_pkg::IDX_W'(1)) : (r_ptr + pal_pkg::IDX_W'(1));
        end
        if (i_cmd.resp) begin
            r_o_status   <= err;
            r_o_moves    <= (!err && is_shift_op) ? moves_cur[pal_pkg::MOVES_W-1:0] : '0;
            r_o_item     <= '0;
            r_o_has_item <= 1'b0;
            r_o_last     <= 1'b1;
            r_o_count    <= n_count;
        end else if (i_cmd.dump_ld) begin
            r_o_status   <= 1'b0;
            r_o_moves    <= '0;
            r_o_item     <= mem_rdata;
            r_o_has_item <= 1'b1;
            r_o_last     <= (r_ptr == cnt_m1);
            r_o_count    <= r_count;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_moves    = r_o_moves;
    assign o_item     = $signed(r_o_item);
    assign o_has_item = r_o_has_item;
    assign o_last     = r_o_last;
    assign o_count    = r_o_count;

endmodule

// ----- rtl/positional_array_list_core.sv -----
// Insert/delete: after the check, the entries to move are shifted one by one, then a drain
//   state lets the last shift write land; an insert then places its value. With nothing to
//   move, shift and drain drop out, and a rejected or unused request goes straight to response.
// Dump: each entry takes a RAM read, then an output load; an empty list goes straight to response.
// Throughput: one request at a time; the next request is taken while a result waits.
// Reset (synchronous, active low) clears the fill count, the controller and output valid.
module positional_array_list_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pal_pkg::FUNC_W-1:0]        i_func,
    input  logic [pal_pkg::POS_W-1:0]         i_position,
    input  logic signed [pal_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_status,
    output logic [pal_pkg::MOVES_W-1:0]       o_moves,
    output logic signed [pal_pkg::DATA_W-1:0] o_item,
    output logic                              o_has_item,
    output logic                              o_last,
    output logic [pal_pkg::CNT_W-1:0]         o_count
);

    // Controller steps the shift, placement, response and dump phases;
    // the datapath holds the list RAM, fill count, pointers and the output register.
    pal_pkg::t_cmd w_cmd;
    pal_pkg::t_sts w_sts;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Shift runs as a read/write pipeline: read one entry, write it one slot
    // over in the next cycle, while the entry after it is read.
    pal_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_func     (i_func),
        .i_position (i_position),
        .i_value    (i_value),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_moves    (o_moves),
        .o_item     (o_item),
        .o_has_item (o_has_item),
        .o_last     (o_last),
        .o_count    (o_count)
    );

    // A request is never taken twice in a row: the controller leaves idle at once.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted on consecutive cycles");

    // A result without an item always closes its request.
    a_noitem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_item) |-> o_last)
        else $error("itemless result not marked last");

    // Dumped entries carry ok status and no moves.
    a_dump_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_item) |-> (!o_status && (o_moves == '0)))
        else $error("dump result with status or moves");

    // An error result reports no moved entries.
    a_err_nomove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_moves == '0))
        else $error("error result with nonzero moves");

endmodule
